>>> hw/rtl/lpht_pkg.sv
package lpht_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SIZE_W = SLOT_W + 1;
   localparam int KEY_W  = 32;
   localparam int HND_W  = 16;
   localparam int KIND_W = 2;
   localparam int ENTRY_W = KEY_W + HND_W;

   // remainder unit: four key bits per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = KEY_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SLOTS);

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   typedef struct packed {
      logic load;      // capture request, start remainder
      logic div_step;  // one remainder iteration
      logic seed;      // probe position from remainder
      logic advance;   // step to next slot with wrap
      logic hit;       // commit operation at current slot
      logic miss;      // refuse / absent
      logic emit;      // move result into output register
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic none;        // unused kind or insert into full table
      logic is_insert;
      logic slot_valid;
      logic steps_done;
      logic key_match;
      logic out_free;
   } dp_sts_type;

endpackage

>>> hw/rtl/lpht_ram.sv
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/lpht_ctrl.sv
module lpht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lpht_pkg::dp_sts_type sts,
   output lpht_pkg::dp_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DIVIDE  = 6'b000010,
      ST_SEED    = 6'b000100,
      ST_PROBE   = 6'b001000,
      ST_COMPARE = 6'b010000,
      ST_RESULT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            if (sts.none) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.seed = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (sts.steps_done) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else if (sts.is_insert) begin
               if (!sts.slot_valid) begin
                  cmd.hit  = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else if (!sts.slot_valid) begin
               cmd.miss = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (sts.key_match) begin
               cmd.hit  = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_PROBE;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/lpht_datapath.sv
module lpht_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lpht_pkg::KIND_W-1:0]         req_kind,
   input  logic [lpht_pkg::KEY_W-1:0]          req_key,
   input  logic [lpht_pkg::HND_W-1:0]          req_handler,
   input  logic                                csr_we,
   input  logic [lpht_pkg::SIZE_W-1:0]         csr_wdata,
   input  lpht_pkg::dp_cmd_type                cmd,
   output lpht_pkg::dp_sts_type                sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_ok,
   output logic [lpht_pkg::HND_W-1:0]          rsp_handler,
   output logic [lpht_pkg::SLOT_W-1:0]         rsp_slot
);

   logic [lpht_pkg::SIZE_W-1:0]  table_size_ff;
   logic [lpht_pkg::SIZE_W-1:0]  size_use;
   logic [lpht_pkg::SIZE_W-1:0]  count_ff, count_in;
   logic [lpht_pkg::SLOTS-1:0]   valid_ff, valid_in;

   logic [lpht_pkg::KIND_W-1:0]  kind_ff;
   logic [lpht_pkg::KEY_W-1:0]   key_ff;
   logic [lpht_pkg::HND_W-1:0]   handler_ff;

   logic [lpht_pkg::KEY_W-1:0]   div_sh_ff, div_sh_in;
   logic [lpht_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [lpht_pkg::SLOT_W-1:0]  rem_ff, rem_in;

   logic [lpht_pkg::SLOT_W-1:0]  pos_ff, pos_in;
   logic [lpht_pkg::SIZE_W-1:0]  steps_ff, steps_in;
   logic [lpht_pkg::SIZE_W-1:0]  pos_inc;

   logic                         res_ok_ff, res_ok_in;
   logic [lpht_pkg::HND_W-1:0]   res_handler_ff, res_handler_in;
   logic [lpht_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_ok_ff;
   logic [lpht_pkg::HND_W-1:0]   out_handler_ff;
   logic [lpht_pkg::SLOT_W-1:0]  out_slot_ff;

   logic                         ram_we;
   logic [lpht_pkg::ENTRY_W-1:0] ram_rdata;
   logic                         is_insert, is_lookup, is_delete;

   assign is_insert = (kind_ff == lpht_pkg::KIND_INSERT);
   assign is_lookup = (kind_ff == lpht_pkg::KIND_LOOKUP);
   assign is_delete = (kind_ff == lpht_pkg::KIND_DELETE);

   // size in use: zero acts as one, oversize clamps to the slot count
   always_comb begin
      if (table_size_ff == '0) begin
         size_use = lpht_pkg::SIZE_W'(1);
      end else if (table_size_ff > lpht_pkg::SIZE_W'(lpht_pkg::SLOTS)) begin
         size_use = lpht_pkg::SIZE_W'(lpht_pkg::SLOTS);
      end else begin
         size_use = table_size_ff;
      end
   end

   // restoring remainder, most significant key bits first
   always_comb begin
      logic [lpht_pkg::SIZE_W-1:0] t;
      logic [lpht_pkg::SLOT_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < lpht_pkg::DIV_BITS; i++) begin
         t = {r, div_sh_ff[lpht_pkg::KEY_W-1-i]};
         if (t >= size_use) begin
            t = t - size_use;
         end
         r = t[lpht_pkg::SLOT_W-1:0];
      end
      rem_in     = rem_ff;
      div_sh_in  = div_sh_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.load) begin
         rem_in     = '0;
         div_sh_in  = req_key;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = r;
         div_sh_in  = div_sh_ff << lpht_pkg::DIV_BITS;
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   assign pos_inc = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      pos_in   = pos_ff;
      steps_in = steps_ff;
      if (cmd.seed) begin
         pos_in   = rem_ff;
         steps_in = '0;
      end else if (cmd.advance) begin
         pos_in   = (pos_inc == size_use) ? '0 : pos_inc[lpht_pkg::SLOT_W-1:0];
         steps_in = steps_ff + 1'b1;
      end
   end

   // commit insert or delete at the current slot
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (cmd.hit && is_insert) begin
         valid_in[pos_ff] = 1'b1;
         count_in         = count_ff + 1'b1;
      end else if (cmd.hit && is_delete) begin
         valid_in[pos_ff] = 1'b0;
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      res_ok_in      = res_ok_ff;
      res_handler_in = res_handler_ff;
      res_slot_in    = res_slot_ff;
      if (cmd.hit) begin
         res_ok_in      = 1'b1;
         res_slot_in    = pos_ff;
         res_handler_in = is_lookup ? ram_rdata[lpht_pkg::ENTRY_W-1:lpht_pkg::KEY_W] : '0;
      end else if (cmd.miss) begin
         res_ok_in      = 1'b0;
         res_slot_in    = '0;
         res_handler_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign ram_we = cmd.hit && is_insert;

   lpht_ram #(
      .WIDTH (lpht_pkg::ENTRY_W),
      .DEPTH (lpht_pkg::SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (pos_ff),
      .wdata ({handler_ff, key_ff}),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= lpht_pkg::SIZE_RESET;
         count_ff      <= '0;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            table_size_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         key_ff     <= req_key;
         handler_ff <= req_handler;
      end
      div_sh_ff      <= div_sh_in;
      div_cnt_ff     <= div_cnt_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      steps_ff       <= steps_in;
      res_ok_ff      <= res_ok_in;
      res_handler_ff <= res_handler_in;
      res_slot_ff    <= res_slot_in;
      if (cmd.emit) begin
         out_ok_ff      <= res_ok_ff;
         out_handler_ff <= res_handler_ff;
         out_slot_ff    <= res_slot_ff;
      end
   end

   assign sts.div_last   = (div_cnt_ff == lpht_pkg::DIV_CNT_W'(lpht_pkg::DIV_STEPS - 1));
   assign sts.none       = !(is_insert || is_lookup || is_delete)
                           || (is_insert && (count_ff >= size_use));
   assign sts.is_insert  = is_insert;
   assign sts.slot_valid = valid_ff[pos_ff];
   assign sts.steps_done = (steps_ff == size_use);
   assign sts.key_match  = (ram_rdata[lpht_pkg::KEY_W-1:0] == key_ff);
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_ok      = out_ok_ff;
   assign rsp_handler = out_handler_ff;
   assign rsp_slot    = out_slot_ff;

endmodule

>>> hw/rtl/linear_probe_hash_table.sv
// Flow: an accepted word goes through the divide, seed and probe states, and its result is
// loaded into the response register. An insert passes each occupied slot in the probe state;
// a lookup or delete takes each slot through the probe and then the compare state (registered
// entry RAM read). Throughput: one request at a time; the next word is taken in the cycle
// after the response is loaded. Key modulo size runs 4 key bits per cycle in the remainder unit.
// Reset: synchronous; clears slot marks and entry count at once, size to 256, no sweep.
module linear_probe_hash_table (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] key, [47:32] handler
   input  logic [1:0]  req_tuser,   // [1:0] kind

   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] handler_out, [23:16] slot
   output logic        rsp_tuser,   // [0] ok

   // size register
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);

   lpht_pkg::dp_cmd_type cmd;
   lpht_pkg::dp_sts_type sts;

   logic [lpht_pkg::HND_W-1:0]  rsp_handler;
   logic [lpht_pkg::SLOT_W-1:0] rsp_slot;

   // sequencer: divide, then walk the probe chain one slot at a time
   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: remainder unit, probe pointer, slot marks, entry RAM, output register
   lpht_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_kind    (req_tuser),
      .req_key     (req_tdata[31:0]),
      .req_handler (req_tdata[47:32]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_ok      (rsp_tuser),
      .rsp_handler (rsp_handler),
      .rsp_slot    (rsp_slot)
   );

   // pack the response word, handler lowest
   assign rsp_tdata = {rsp_slot, rsp_handler};

endmodule
